@@ hdl/rpd_pkg.sv @@
// Shared types, character codes and decode helpers for the packet deframer.
`default_nettype none

package rpd_pkg;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_ESC   = 8'h7D;  // '}'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [7:0] CH_NAK   = 8'h2D;  // '-'

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_RESTART = 2'd1,
    EV_ACCEPT  = 2'd2,
    EV_REJECT  = 2'd3
  } event_kind_t;

  typedef enum logic [3:0] {
    PH_BODY = 4'b0001,
    PH_ESC  = 4'b0010,
    PH_HI   = 4'b0100,
    PH_LO   = 4'b1000
  } phase_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  payload_byte;
    logic        bad_escape;
    logic [7:0]  sum_received;
    logic [7:0]  sum_computed;
  } result_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
      end
      return d[3:0];
    end
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return (c == CH_START) || (c == CH_END) || (c == CH_ESC) || (c == CH_STAR);
  endfunction

endpackage

`default_nettype wire

@@ hdl/rpd_in_stage.sv @@
// Input register for received words, released into the decoder when the result side has room.
`default_nettype none

module rpd_in_stage
  import rpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       room,
  output logic            take,
  output logic [7:0]      byte_q
);

  logic       full_r, full_nxt;
  logic [7:0] byte_r;
  logic       load;

  assign take     = full_r & room;
  assign in_stall = full_r & ~room;
  assign load     = in_valid & ~in_stall;
  assign full_nxt = load | (full_r & ~take);
  assign byte_q   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rpd_core.sv @@
// Framing state, running checksum and per-word decode.
`default_nettype none

module rpd_core
  import rpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] byte_q,
  output logic            res_ok,
  output result_t         res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic [7:0] unesc;
  logic [7:0] rcv;
  logic [7:0] sum_add;

  assign unesc   = byte_q ^ ESC_XOR;
  assign rcv     = {hi_r, hex_value(byte_q)};
  assign sum_add = sum_r + byte_q;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    hi_nxt    = hi_r;
    res_ok    = 1'b0;
    res       = '{kind: EV_PAYLOAD, payload_byte: 8'h00, bad_escape: 1'b0,
                  sum_received: 8'h00, sum_computed: 8'h00};
    unique case (phase_r)
      PH_ESC: begin
        sum_nxt          = sum_add;
        phase_nxt        = PH_BODY;
        res_ok           = 1'b1;
        res.payload_byte = unesc;
        res.bad_escape   = ~is_special(unesc);
      end
      PH_HI: begin
        hi_nxt    = hex_value(byte_q);
        phase_nxt = PH_LO;
      end
      PH_LO: begin
        sum_nxt          = 8'h00;
        phase_nxt        = PH_BODY;
        res_ok           = 1'b1;
        // a zero checksum is taken as "don't check"
        res.kind         = (rcv != 8'h00 && rcv != sum_r) ? EV_REJECT : EV_ACCEPT;
        res.sum_received = rcv;
        res.sum_computed = sum_r;
      end
      default: begin
        priority if (byte_q == CH_START) begin
          sum_nxt  = 8'h00;
          res_ok   = 1'b1;
          res.kind = EV_RESTART;
        end else if (byte_q == CH_END) begin
          phase_nxt = PH_HI;
        end else if (byte_q == CH_ESC) begin
          sum_nxt   = sum_add;
          phase_nxt = PH_ESC;
        end else begin
          sum_nxt          = sum_add;
          res_ok           = 1'b1;
          res.payload_byte = byte_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BODY;
      sum_r   <= 8'h00;
      hi_r    <= 4'h0;
    end else if (take) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      hi_r    <= hi_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rpd_out_stage.sv @@
// Result register; holds a word until the consumer drops stall.
`default_nettype none

module rpd_out_stage
  import rpd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    take,
  input  wire logic    res_ok,
  input  wire result_t res,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      res_q
);

  logic    valid_r, valid_nxt;
  result_t res_r;
  logic    load;

  assign room      = ~valid_r | ~out_stall;
  assign load      = take & res_ok;
  assign valid_nxt = load | (valid_r & out_stall);
  assign out_valid = valid_r;
  assign res_q     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rsp_packet_deframer.sv @@
// Top level of the debugger serial packet deframer.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_stall    in_rx_byte[7:0]
//   out_     out  out_valid / out_stall  out_event_kind[1:0], out_payload_byte[7:0],
//                                        out_bad_escape, out_sum_received[7:0],
//                                        out_sum_computed[7:0]
//
// One word per cycle sustained while out_stall is low. A word is held in the input register
// and then decoded into the result register, whose valid flag drives out_valid.
// Synchronous reset puts the framer in the body phase with a zero sum.
// out_stall holds the result register and, if the input register is also full, in_stall.
// '#' and '}' and the first checksum digit give no result word.
`default_nettype none

module rsp_packet_deframer
  import rpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_event_kind,
  output logic [7:0]      out_payload_byte,
  output logic            out_bad_escape,
  output logic [7:0]      out_sum_received,
  output logic [7:0]      out_sum_computed
);

  logic       room;
  logic       take;
  logic [7:0] byte_q;
  logic       res_ok;
  result_t    res;
  result_t    res_q;

  rpd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .room       (room),
    .take       (take),
    .byte_q     (byte_q)
  );

  rpd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .byte_q (byte_q),
    .res_ok (res_ok),
    .res    (res)
  );

  rpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .res_ok    (res_ok),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_q     (res_q)
  );

  assign out_event_kind   = res_q.kind;
  assign out_payload_byte = res_q.payload_byte;
  assign out_bad_escape   = res_q.bad_escape;
  assign out_sum_received = res_q.sum_received;
  assign out_sum_computed = res_q.sum_computed;

`ifndef NO_ASSERTIONS
  a_verdict_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (res_q.kind == EV_ACCEPT) |->
      (res_q.sum_received == 8'h00) || (res_q.sum_received == res_q.sum_computed))
    else $error("accept with mismatching checksum");

  a_verdict_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (res_q.kind == EV_REJECT) |->
      (res_q.sum_received != 8'h00) && (res_q.sum_received != res_q.sum_computed))
    else $error("reject with matching or zero checksum");

  a_no_sums_on_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((res_q.kind == EV_PAYLOAD) || (res_q.kind == EV_RESTART)) |->
      (res_q.sum_received == 8'h00) && (res_q.sum_computed == 8'h00))
    else $error("checksum fields set on data or restart word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !take)
    else $error("decoder advanced while result register held");
`endif

endmodule

`default_nettype wire
